@@ hdl/jsu_pkg.sv @@
// Shared types, phase codes, character codes and helpers for the string unescape unit.
package jsu_pkg;

  // Decoder phase
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_STR  = 3'd1,
    PH_ESC  = 3'd2,
    PH_HEX0 = 3'd3,
    PH_HEX1 = 3'd4,
    PH_HEX2 = 3'd5,
    PH_HEX3 = 3'd6
  } phase_t;

  // Error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_ESCAPE   = 3'd1;
  localparam logic [2:0] ERR_UNICODE  = 3'd2;
  localparam logic [2:0] ERR_UNTERM   = 3'd3;
  localparam logic [2:0] ERR_NO_QUOTE = 3'd4;

  // Character codes
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_U         = 8'h75;
  localparam logic [7:0] CC_BS        = 8'h08;
  localparam logic [7:0] CC_FF        = 8'h0C;
  localparam logic [7:0] CC_LF        = 8'h0A;
  localparam logic [7:0] CC_CR        = 8'h0D;
  localparam logic [7:0] CC_TAB       = 8'h09;

  // UTF-8 limits and lead/continuation marks
  localparam logic [15:0] UTF_MAX1   = 16'h007F;
  localparam logic [15:0] UTF_MAX2   = 16'h07FF;
  localparam logic [7:0]  UTF_LEAD2  = 8'hC0;
  localparam logic [7:0]  UTF_LEAD3  = 8'hE0;
  localparam logic [7:0]  UTF_CONT   = 8'h80;
  localparam logic [7:0]  UTF_MASK6  = 8'h3F;

  // One input transaction
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } item_t;

  // One output transaction
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_done;
    logic [2:0] error_code;
    logic       last;
  } result_t;

  // All results caused by one input item
  typedef struct packed {
    logic [1:0] count;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic       string_done;
    logic [2:0] error_code;
  } group_t;

  // Hex digit decode: bit 4 set when the byte is a hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end
    return r;
  endfunction

endpackage

@@ hdl/jsu_decode.sv @@
// Decoder: phase and hex accumulator state, maps one input item to its result group.
module jsu_decode (
  input  logic           clk,
  input  logic           rst,
  input  logic           fire,
  input  jsu_pkg::item_t item,
  output jsu_pkg::group_t grp
);

  jsu_pkg::phase_t phase, phase_next;
  logic [11:0]     hex_accum, hex_accum_next;
  logic [4:0]      dig;
  logic [15:0]     code;
  logic [7:0]      b;
  logic            eoi;

  assign b    = item.data_byte;
  assign eoi  = item.end_of_input;
  assign dig  = jsu_pkg::hex_digit(b);
  assign code = {hex_accum, dig[3:0]};

  // Next state and result group
  always_comb begin
    phase_next     = phase;
    hex_accum_next = hex_accum;
    grp            = '0;
    case (phase)
      jsu_pkg::PH_STR: begin
        if (eoi) begin
          grp.count      = 2'd1;
          grp.error_code = jsu_pkg::ERR_UNTERM;
          phase_next     = jsu_pkg::PH_IDLE;
          hex_accum_next = '0;
        end else if (b == jsu_pkg::CH_QUOTE) begin
          grp.count       = 2'd1;
          grp.string_done = 1'b1;
          phase_next      = jsu_pkg::PH_IDLE;
        end else if (b == jsu_pkg::CH_BACKSLASH) begin
          phase_next = jsu_pkg::PH_ESC;
        end else begin
          grp.count = 2'd1;
          grp.byte0 = b;
        end
      end
      jsu_pkg::PH_ESC: begin
        if (eoi) begin
          grp.count      = 2'd1;
          grp.error_code = jsu_pkg::ERR_ESCAPE;
          phase_next     = jsu_pkg::PH_IDLE;
          hex_accum_next = '0;
        end else begin
          grp.count  = 2'd1;
          phase_next = jsu_pkg::PH_STR;
          case (b)
            jsu_pkg::CH_QUOTE:     grp.byte0 = jsu_pkg::CH_QUOTE;
            jsu_pkg::CH_BACKSLASH: grp.byte0 = jsu_pkg::CH_BACKSLASH;
            jsu_pkg::CH_SLASH:     grp.byte0 = jsu_pkg::CH_SLASH;
            jsu_pkg::CH_B:         grp.byte0 = jsu_pkg::CC_BS;
            jsu_pkg::CH_F:         grp.byte0 = jsu_pkg::CC_FF;
            jsu_pkg::CH_N:         grp.byte0 = jsu_pkg::CC_LF;
            jsu_pkg::CH_R:         grp.byte0 = jsu_pkg::CC_CR;
            jsu_pkg::CH_T:         grp.byte0 = jsu_pkg::CC_TAB;
            jsu_pkg::CH_U: begin
              grp.count      = 2'd0;
              phase_next     = jsu_pkg::PH_HEX0;
              hex_accum_next = '0;
            end
            default: begin
              grp.error_code = jsu_pkg::ERR_ESCAPE;
              phase_next     = jsu_pkg::PH_IDLE;
              hex_accum_next = '0;
            end
          endcase
        end
      end
      jsu_pkg::PH_HEX0, jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2, jsu_pkg::PH_HEX3: begin
        if (eoi || !dig[4]) begin
          grp.count      = 2'd1;
          grp.error_code = jsu_pkg::ERR_UNICODE;
          phase_next     = jsu_pkg::PH_IDLE;
          hex_accum_next = '0;
        end else if (phase == jsu_pkg::PH_HEX3) begin
          // Fourth digit: emit the code point as UTF-8
          hex_accum_next = '0;
          phase_next     = jsu_pkg::PH_STR;
          if (code <= jsu_pkg::UTF_MAX1) begin
            grp.count = 2'd1;
            grp.byte0 = code[7:0];
          end else if (code <= jsu_pkg::UTF_MAX2) begin
            grp.count = 2'd2;
            grp.byte0 = jsu_pkg::UTF_LEAD2 | {3'd0, code[10:6]};
            grp.byte1 = jsu_pkg::UTF_CONT | ({2'd0, code[5:0]} & jsu_pkg::UTF_MASK6);
          end else begin
            grp.count = 2'd3;
            grp.byte0 = jsu_pkg::UTF_LEAD3 | {4'd0, code[15:12]};
            grp.byte1 = jsu_pkg::UTF_CONT | ({2'd0, code[11:6]} & jsu_pkg::UTF_MASK6);
            grp.byte2 = jsu_pkg::UTF_CONT | ({2'd0, code[5:0]} & jsu_pkg::UTF_MASK6);
          end
        end else begin
          hex_accum_next = {hex_accum[7:0], dig[3:0]};
          phase_next     = jsu_pkg::phase_t'(phase + 3'd1);
        end
      end
      default: begin
        // Idle: wait for the opening quote; any other input is a missing-quote error
        hex_accum_next = '0;
        if (!eoi && b == jsu_pkg::CH_QUOTE) begin
          phase_next = jsu_pkg::PH_STR;
        end else begin
          grp.count      = 2'd1;
          grp.error_code = jsu_pkg::ERR_NO_QUOTE;
          phase_next     = jsu_pkg::PH_IDLE;
        end
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= jsu_pkg::PH_IDLE;
      hex_accum <= '0;
    end else if (fire) begin
      phase     <= phase_next;
      hex_accum <= hex_accum_next;
    end
  end

endmodule

@@ hdl/jsu_out.sv @@
// Result register: holds one group, sends one transaction per cycle unless stalled.
module jsu_out (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  jsu_pkg::group_t  grp,
  input  logic             result_stall,
  output logic             result_valid,
  output jsu_pkg::result_t result,
  output logic             can_load
);

  logic [1:0] cnt;
  logic [7:0] b0, b1, b2;
  logic       done;
  logic [2:0] err;
  logic       pop;

  assign result_valid = (cnt != 2'd0);
  assign pop          = result_valid && !result_stall;
  // Room once the held group is empty or its final transaction leaves now
  assign can_load     = (cnt == 2'd0) || (cnt == 2'd1 && !result_stall);

  always_comb begin
    result.byte_valid  = !done && (err == jsu_pkg::ERR_NONE);
    result.out_byte    = b0;
    result.string_done = done;
    result.error_code  = err;
    result.last        = (cnt == 2'd1);
  end

  // Count of pending results
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= grp.count;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  // Payload: shift down on each transaction
  always_ff @(posedge clk) begin
    if (load) begin
      b0   <= grp.byte0;
      b1   <= grp.byte1;
      b2   <= grp.byte2;
      done <= grp.string_done;
      err  <= grp.error_code;
    end else if (pop) begin
      b0 <= b1;
      b1 <= b2;
    end
  end

endmodule

@@ hdl/json_string_unescape_unit.sv @@
// Top level of the JSON string unescape unit: input register, decoder, result register.
//
// Input channel (item_valid / item_stall / item): one string byte, or an end-of-input
// mark, per transaction, starting at the opening quote. Output channel (result_valid /
// result_stall / result): decoded bytes, plus one done or error transaction that ends
// a string. Each input causes zero to three results; the last carries the last flag.
// An accepted input waits in the input register until the result register has room.
// Throughput: one input per cycle while each input yields at most one result and
// result_stall is low. A \u escape that expands to two or three UTF-8 bytes holds
// the result register until they leave; the next input waits in the input register.
// The single result register, drained one per cycle unless stalled, sets this figure.
// A new input is taken while a result still waits to be taken, as long as the input
// register is free or moves into the decoder in that cycle.
// Reset (rst, synchronous) empties both registers and puts the decoder back to waiting
// for an opening quote. While result_stall is high the shown result holds; the input
// register fills and then item_stall rises.
module json_string_unescape_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  jsu_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output jsu_pkg::result_t result
);

  logic            hold_valid;
  jsu_pkg::item_t  hold;
  logic            accept;
  logic            fire;
  logic            can_load;
  jsu_pkg::group_t grp;

  assign fire       = hold_valid && can_load;
  assign item_stall = hold_valid && !can_load;
  assign accept     = item_valid && !item_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= accept || (hold_valid && !fire);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold <= item;
    end
  end

  jsu_decode u_decode (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (hold),
    .grp  (grp)
  );

  jsu_out u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (fire),
    .grp          (grp),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result),
    .can_load     (can_load)
  );

endmodule

@@ hdl/jsu_checker.sv @@
// Port-level checks for the unescape unit and their attachment to the top level.
module jsu_checker (
  input logic             clk,
  input logic             rst,
  input logic             result_valid,
  input logic             result_stall,
  input jsu_pkg::result_t result
);

  // Nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result offered right after reset");

  // A stalled transaction holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // A decoded byte never carries an end mark
  a_byte_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.byte_valid |->
      result.error_code == jsu_pkg::ERR_NONE && !result.string_done)
    else $error("decoded byte carries done or error");

  // Done and error transactions close their input's results
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.string_done || result.error_code != jsu_pkg::ERR_NONE) |->
      result.last && result.out_byte == 8'd0)
    else $error("end transaction not last or nonzero byte");

  // Error codes stay in range
  a_err_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.error_code <= jsu_pkg::ERR_NO_QUOTE)
    else $error("error code out of range");

endmodule

bind json_string_unescape_unit jsu_checker u_jsu_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
